/* src/rbag_pkg.sv */
`default_nettype none
package rbag_pkg;

    localparam int RBAG_MAX_EDGE   = 256;
    localparam int RBAG_SIZE_RESET = 256;
    localparam int RBAG_QW         = 32;
    localparam int RBAG_RW         = 16;
    localparam int RBAG_CW         = 31;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_in;

    typedef struct packed {
        logic [7:0] alpha;
        logic       coord_invalid;
    } t_out;

    typedef struct packed {
        logic valid;
        logic zero;
        logic invalid;
    } t_side;

endpackage
`default_nettype wire

/* src/rbag_prep.sv */
`default_nettype none
module rbag_prep import rbag_pkg::*; #(
    parameter int  MAX_EDGE = RBAG_MAX_EDGE,
    localparam int EW       = $clog2(MAX_EDGE),
    localparam int DW       = 2 * EW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_in           i_data,
    input  wire logic [8:0]    i_blob_size,
    output t_side              o_side,
    output logic [DW-1:0]      o_num,
    output logic [DW-1:0]      o_dd
);

    logic [31:0] s32;
    logic [31:0] d32;
    logic        inv;

    always_comb begin
        if ({23'd0, i_blob_size} > 32'(MAX_EDGE)) begin
            s32 = 32'(MAX_EDGE);
        end else begin
            s32 = {23'd0, i_blob_size};
        end
        d32 = s32 - 32'd1;
        inv = (s32 < 32'd2) || ({24'd0, i_data.pixel_x} >= s32) ||
              ({24'd0, i_data.pixel_y} >= s32);
    end

    t_side         r_side1, r_side2, r_side3, r_side4;
    logic [7:0]    r_x, r_y;
    logic [EW-1:0] r_d1, r_d2;
    logic [EW-1:0] r_ex, r_ey;
    logic [DW:0]   r_num3;
    logic [DW-1:0] r_dd3, r_num4, r_dd4;

    logic [31:0]   x2, y2, dd32, ex32, ey32;
    logic [DW-1:0] sx, sy, sd;

    always_comb begin
        x2   = {23'd0, r_x, 1'b0};
        y2   = {23'd0, r_y, 1'b0};
        dd32 = {{(32-EW){1'b0}}, r_d1};
        ex32 = (x2 >= dd32) ? x2 - dd32 : dd32 - x2;
        ey32 = (y2 >= dd32) ? y2 - dd32 : dd32 - y2;
        sx   = {{EW{1'b0}}, r_ex} * {{EW{1'b0}}, r_ex};
        sy   = {{EW{1'b0}}, r_ey} * {{EW{1'b0}}, r_ey};
        sd   = {{EW{1'b0}}, r_d2} * {{EW{1'b0}}, r_d2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
            r_side3 <= '0;
            r_side4 <= '0;
        end else if (i_en) begin
            r_side1 <= '{valid: i_valid, zero: inv, invalid: inv};
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            r_side4 <= '{valid: r_side3.valid,
                         zero: r_side3.zero | (r_num3 >= {1'b0, r_dd3}),
                         invalid: r_side3.invalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= i_data.pixel_x;
            r_y    <= i_data.pixel_y;
            r_d1   <= d32[EW-1:0];
            r_ex   <= ex32[EW-1:0];
            r_ey   <= ey32[EW-1:0];
            r_d2   <= r_d1;
            r_num3 <= {1'b0, sx} + {1'b0, sy};
            r_dd3  <= sd;
            r_num4 <= r_num3[DW-1:0];
            r_dd4  <= r_dd3;
        end
    end

    assign o_side = r_side4;
    assign o_num  = r_num4;
    assign o_dd   = r_dd4;

endmodule
`default_nettype wire

/* src/rbag_div.sv */
`default_nettype none
module rbag_div import rbag_pkg::*; #(
    parameter int  MAX_EDGE = RBAG_MAX_EDGE,
    localparam int EW       = $clog2(MAX_EDGE),
    localparam int DW       = 2 * EW
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_side             i_side,
    input  wire logic [DW-1:0]     i_num,
    input  wire logic [DW-1:0]     i_dd,
    output t_side                  o_side,
    output logic [RBAG_QW-1:0]     o_q
);

    logic [DW-1:0]      s_rem  [RBAG_QW+1];
    logic [DW-1:0]      s_dd   [RBAG_QW+1];
    logic [RBAG_QW-1:0] s_q    [RBAG_QW+1];
    t_side              s_side [RBAG_QW+1];

    assign s_rem[0]  = i_num;
    assign s_dd[0]   = i_dd;
    assign s_q[0]    = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < RBAG_QW; k++) begin : g_bit
        logic [DW:0]        sh;
        logic               ge;
        logic [DW:0]        diff;
        logic [DW-1:0]      r_rem, r_dd;
        logic [RBAG_QW-1:0] r_q;
        t_side              r_side;

        assign sh   = {s_rem[k], 1'b0};
        assign ge   = sh >= {1'b0, s_dd[k]};
        assign diff = sh - {1'b0, s_dd[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= s_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
                r_dd  <= s_dd[k];
                r_q   <= {s_q[k][RBAG_QW-2:0], ge};
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_dd[k+1]   = r_dd;
        assign s_q[k+1]    = r_q;
        assign s_side[k+1] = r_side;
    end

    assign o_side = s_side[RBAG_QW];
    assign o_q    = s_q[RBAG_QW];

endmodule
`default_nettype wire

/* src/rbag_sqrt.sv */
`default_nettype none
module rbag_sqrt import rbag_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_side             i_side,
    input  wire logic [RBAG_QW-1:0] i_q,
    output t_side                  o_side,
    output logic [RBAG_RW-1:0]     o_root
);

    logic [RBAG_RW+1:0] s_rem  [RBAG_RW+1];
    logic [RBAG_RW-1:0] s_root [RBAG_RW+1];
    logic [RBAG_QW-1:0] s_q    [RBAG_RW+1];
    t_side              s_side [RBAG_RW+1];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_q[0]    = i_q;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < RBAG_RW; k++) begin : g_digit
        logic [RBAG_RW+1:0] rin, trial;
        logic               ge;
        logic [RBAG_RW+1:0] r_rem;
        logic [RBAG_RW-1:0] r_root;
        logic [RBAG_QW-1:0] r_q;
        t_side              r_side;

        assign rin   = {s_rem[k][RBAG_RW-1:0], s_q[k][RBAG_QW-1:RBAG_QW-2]};
        assign trial = {s_root[k], 2'b01};
        assign ge    = rin >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= s_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? rin - trial : rin;
                r_root <= {s_root[k][RBAG_RW-2:0], ge};
                r_q    <= {s_q[k][RBAG_QW-3:0], 2'b00};
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_q[k+1]    = r_q;
        assign s_side[k+1] = r_side;
    end

    assign o_side = s_side[RBAG_RW];
    assign o_root = s_root[RBAG_RW];

endmodule
`default_nettype wire

/* src/rbag_cos.sv */
`default_nettype none
module rbag_cos import rbag_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire t_side              i_side,
    input  wire logic [RBAG_RW-1:0] i_r,
    output t_side                   o_side,
    output logic [RBAG_CW-1:0]      o_cos
);

    localparam logic [46:0] HALF_PI = 47'd1686629713;
    localparam logic [RBAG_CW-1:0] ONE = 31'h4000_0000;
    localparam logic [31:0] HK [5] = '{32'd90, 32'd56, 32'd30, 32'd12, 32'd2};

    logic [46:0] th_p;
    logic [61:0] z_p;
    t_side       r_side_t, r_side_z;
    logic [30:0] r_theta;
    logic [31:0] r_z;

    assign th_p = {31'd0, i_r} * HALF_PI;
    assign z_p  = {31'd0, r_theta} * {31'd0, r_theta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_t <= '0;
            r_side_z <= '0;
        end else if (i_en) begin
            r_side_t <= i_side;
            r_side_z <= r_side_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_theta <= th_p[46:16];
            r_z     <= z_p[61:30];
        end
    end

    logic [31:0]        s_z    [6];
    logic [RBAG_CW-1:0] s_b    [6];
    t_side              s_side [6];

    assign s_z[0]    = r_z;
    assign s_b[0]    = ONE;
    assign s_side[0] = r_side_z;

    for (genvar j = 0; j < 5; j++) begin : g_step
        localparam logic [31:0] K = HK[j];
        localparam logic [63:0] M = 64'h1_0000_0000 / {32'd0, K};

        logic [62:0] pa;
        logic [63:0] pm;
        logic [31:0] rem, t;
        logic [31:0] r_pa, r_pb, r_qe, r_za, r_zb, r_zc;
        logic [RBAG_CW-1:0] r_b;
        t_side       r_sa, r_sb, r_sc;

        assign pa  = {31'd0, s_z[j]} * {32'd0, s_b[j]};
        assign pm  = {32'd0, r_pa} * {32'd0, M[31:0]};
        assign rem = r_pb - 32'(r_qe * K);
        assign t   = (rem >= K) ? r_qe + 32'd1 : r_qe;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa <= '0;
                r_sb <= '0;
                r_sc <= '0;
            end else if (i_en) begin
                r_sa <= s_side[j];
                r_sb <= r_sa;
                r_sc <= r_sb;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa <= pa[61:30];
                r_za <= s_z[j];
                r_qe <= pm[63:32];
                r_pb <= r_pa;
                r_zb <= r_za;
                r_b  <= (t >= {1'b0, ONE}) ? '0 : ONE - t[RBAG_CW-1:0];
                r_zc <= r_zb;
            end
        end

        assign s_z[j+1]    = r_zc;
        assign s_b[j+1]    = r_b;
        assign s_side[j+1] = r_sc;
    end

    assign o_side = s_side[5];
    assign o_cos  = s_b[5];

endmodule
`default_nettype wire

/* src/rbag_alpha.sv */
`default_nettype none
module rbag_alpha import rbag_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire t_side              i_side,
    input  wire logic [RBAG_CW-1:0] i_cos,
    output logic                    o_valid,
    output t_out                    o_data
);

    logic [61:0] cc;
    logic [62:0] fsum;
    logic [33:0] g;
    logic [22:0] h;
    logic [55:0] gh;
    logic [63:0] n;
    logic [24:0] qp;
    logic [15:0] rem;
    logic [8:0]  a;

    logic [16:0] r_f;
    logic [33:0] r_g;
    logic [22:0] r_h;
    logic [55:0] r_gh;
    logic [15:0] r_v4, r_v5;
    logic [8:0]  r_qe;
    t_side       r_s1, r_s2, r_s3, r_s4, r_s5;
    logic        r_valid;
    t_out        r_data;

    assign cc   = {31'd0, i_cos} * {31'd0, i_cos};
    assign fsum = {1'b0, cc} + (63'd1 << 43);
    assign g    = {17'd0, r_f} * {17'd0, r_f};
    assign h    = 23'd3604480 + 23'({6'd0, r_f} * 23'd45);
    assign gh   = {23'd0, r_g[32:0]} * {33'd0, r_h};
    assign n    = {r_gh, 8'd0} - {8'd0, r_gh};
    assign qp   = {9'd0, r_v4} * 25'd655;
    assign rem  = r_v5 - 16'({7'd0, r_qe} * 16'd100);
    assign a    = (rem >= 16'd100) ? r_qe + 9'd1 : r_qe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_s4    <= '0;
            r_s5    <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_s1    <= i_side;
            r_s2    <= r_s1;
            r_s3    <= r_s2;
            r_s4    <= r_s3;
            r_s5    <= r_s4;
            r_valid <= r_s5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f  <= fsum[60:44];
            r_g  <= g;
            r_h  <= h;
            r_gh <= gh;
            r_v4 <= n[63:48] + 16'd50;
            r_qe <= qp[24:16];
            r_v5 <= r_v4;
            r_data.coord_invalid <= r_s5.invalid;
            if (r_s5.zero) begin
                r_data.alpha <= 8'd0;
            end else if (a > 9'd255) begin
                r_data.alpha <= 8'd255;
            end else begin
                r_data.alpha <= a[7:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

/* src/radial_blob_alpha_generator.sv */
// Pipeline: from input transaction to result, 4 setup, 32 divider (one quotient bit per stage),
// 16 square root, 17 cosine and 6 alpha stages.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous active low; clears all valid bits, blob_size returns to 256.
`default_nettype none
module radial_blob_alpha_generator import rbag_pkg::*; #(
    parameter int MAX_EDGE = RBAG_MAX_EDGE
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in        i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out            o_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [8:0] i_cfg_data
);

    localparam int EW = $clog2(MAX_EDGE);
    localparam int DW = 2 * EW;

    logic               en;
    logic [8:0]         r_blob_size;
    t_side              prep_side, div_side, sqrt_side, cos_side;
    logic [DW-1:0]      prep_num, prep_dd;
    logic [RBAG_QW-1:0] div_q;
    logic [RBAG_RW-1:0] sqrt_root;
    logic [RBAG_CW-1:0] cos_val;

    assign en          = !o_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blob_size <= 9'(RBAG_SIZE_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blob_size <= i_cfg_data;
        end
    end

    rbag_prep #(.MAX_EDGE(MAX_EDGE)) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .i_blob_size(r_blob_size),
        .o_side     (prep_side),
        .o_num      (prep_num),
        .o_dd       (prep_dd)
    );

    rbag_div #(.MAX_EDGE(MAX_EDGE)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (prep_side),
        .i_num  (prep_num),
        .i_dd   (prep_dd),
        .o_side (div_side),
        .o_q    (div_q)
    );

    rbag_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (div_side),
        .i_q    (div_q),
        .o_side (sqrt_side),
        .o_root (sqrt_root)
    );

    rbag_cos u_cos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (sqrt_side),
        .i_r    (sqrt_root),
        .o_side (cos_side),
        .o_cos  (cos_val)
    );

    rbag_alpha u_alpha (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (cos_side),
        .i_cos  (cos_val),
        .o_valid(o_valid),
        .o_data (o_data)
    );

endmodule
`default_nettype wire

/* dv/radial_blob_alpha_generator_tb.sv */
`default_nettype none
module radial_blob_alpha_generator_tb;
    import rbag_pkg::*;

    localparam int LATENCY     = 75;
    localparam int CYCLE_LIMIT = 600000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in        i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out       o_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data = '0;

    t_out        expected_alpha[$];
    int unsigned cur_size = RBAG_SIZE_RESET;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    radial_blob_alpha_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned cos_q30(longint unsigned theta);
        longint unsigned k_div[5];
        longint unsigned z;
        longint unsigned b;
        longint unsigned t;
        k_div = '{64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
        z = (theta * theta) >> 30;
        b = 64'd1 << 30;
        for (int i = 0; i < 5; i++) begin
            t = ((z * b) >> 30) / k_div[i];
            b = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
        end
        return b;
    endfunction

    function automatic t_out shade_pixel(int unsigned size, logic [7:0] px, logic [7:0] py);
        longint unsigned s, d, dd, ex, ey, num, r_q, theta, c, f, n, den, a;
        t_out res;
        s = (size > RBAG_MAX_EDGE) ? RBAG_MAX_EDGE : size;
        res = '0;
        if (s < 2 || px >= s || py >= s) begin
            res.coord_invalid = 1'b1;
            return res;
        end
        d  = s - 1;
        dd = d * d;
        ex = (2 * px >= d) ? 2 * px - d : d - 2 * px;
        ey = (2 * py >= d) ? 2 * py - d : d - 2 * py;
        num = ex * ex + ey * ey;
        a = 0;
        if (num < dd) begin
            r_q   = isqrt64((num << 32) / dd);
            theta = (r_q * 64'd1686629713) >> 16;
            c     = cos_q30(theta);
            f     = (c * c + (64'd1 << 43)) >> 44;
            den   = 64'd100 << 48;
            n     = 64'd255 * (f * f) * (64'd55 * 64'd65536 + 64'd45 * f);
            a     = (n + den / 2) / den;
            if (a > 255) a = 255;
        end
        res.alpha = a[7:0];
        return res;
    endfunction

    task automatic drain_results();
        wait (expected_alpha.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_blob_size(int unsigned size);
        if (i_valid) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size[8:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_size = size;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // push the expectation at the accepting edge
    task automatic send_pixel(logic [7:0] px, logic [7:0] py, bit known, t_out known_val);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= '{pixel_x: px, pixel_y: py};
        do @(posedge i_clk); while (o_stall);
        expected_alpha.push_back(known ? known_val : shade_pixel(cur_size, px, py));
    endtask

    typedef struct {
        int unsigned size;
        logic [7:0]  px;
        logic [7:0]  py;
        bit          known;
        logic [7:0]  alpha;
        logic        inv;
    } t_row;

    t_row directed_rows[] = '{
        '{256, 8'd0,   8'd0,   1, 8'd0,   1'b0},
        '{256, 8'd255, 8'd255, 1, 8'd0,   1'b0},
        '{256, 8'd255, 8'd0,   1, 8'd0,   1'b0},
        '{256, 8'd127, 8'd128, 0, 8'd0,   1'b0},
        '{256, 8'd127, 8'd60,  0, 8'd0,   1'b0},
        '{256, 8'd200, 8'd90,  0, 8'd0,   1'b0},
        '{3,   8'd1,   8'd1,   1, 8'd255, 1'b0},
        '{3,   8'd0,   8'd1,   1, 8'd0,   1'b0},
        '{3,   8'd3,   8'd1,   1, 8'd0,   1'b1},
        '{3,   8'd255, 8'd255, 1, 8'd0,   1'b1},
        '{2,   8'd0,   8'd0,   1, 8'd0,   1'b0},
        '{2,   8'd1,   8'd2,   1, 8'd0,   1'b1},
        '{1,   8'd0,   8'd0,   1, 8'd0,   1'b1},
        '{0,   8'd0,   8'd0,   1, 8'd0,   1'b1},
        '{0,   8'd170, 8'd85,  1, 8'd0,   1'b1},
        '{200, 8'd200, 8'd10,  1, 8'd0,   1'b1},
        '{200, 8'd10,  8'd199, 0, 8'd0,   1'b0},
        '{200, 8'd100, 8'd99,  0, 8'd0,   1'b0},
        '{511, 8'd255, 8'd255, 1, 8'd0,   1'b0},
        '{511, 8'd128, 8'd127, 0, 8'd0,   1'b0},
        '{257, 8'd85,  8'd170, 0, 8'd0,   1'b0},
        '{256, 8'd64,  8'd64,  0, 8'd0,   1'b0}
    };

    int unsigned block_sizes[11] = '{256, 5, 2, 17, 511, 1, 100, 3, 255, 0, 257};

    initial begin
        int unsigned lim;
        int unsigned sz;
        logic [7:0]  px, py;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].size != cur_size) write_blob_size(directed_rows[i].size);
            send_pixel(directed_rows[i].px, directed_rows[i].py, directed_rows[i].known,
                       '{alpha: directed_rows[i].alpha, coord_invalid: directed_rows[i].inv});
        end

        for (int blk = 0; blk < 12; blk++) begin
            sz = (blk < 11) ? block_sizes[blk] : $urandom_range(4, 254);
            write_blob_size(sz);
            case (blk % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            // long receiver hold while the sender keeps pushing
            if (blk == 4) hold_cycles = 300;
            lim = (sz > 256) ? 256 : sz;
            for (int k = 0; k < 140; k++) begin
                if (lim >= 1 && $urandom_range(0, 99) < 85) begin
                    px = 8'($urandom_range(0, lim - 1));
                    py = 8'($urandom_range(0, lim - 1));
                end else begin
                    px = 8'($urandom_range(0, 255));
                    py = 8'($urandom_range(0, 255));
                end
                send_pixel(px, py, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (expected_alpha.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out exp_val;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_alpha.size() == 0) begin
                $error("unexpected transaction: alpha %0d coord_invalid %0b",
                       o_data.alpha, o_data.coord_invalid);
                fail_count = fail_count + 1;
            end else begin
                exp_val = expected_alpha.pop_front();
                if (o_data.alpha !== exp_val.alpha) begin
                    $error("alpha: expected %0d actual %0d", exp_val.alpha, o_data.alpha);
                    fail_count = fail_count + 1;
                end
                if (o_data.coord_invalid !== exp_val.coord_invalid) begin
                    $error("coord_invalid: expected %0b actual %0b",
                           exp_val.coord_invalid, o_data.coord_invalid);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* filelist.f */
src/rbag_pkg.sv
src/rbag_prep.sv
src/rbag_div.sv
src/rbag_sqrt.sv
src/rbag_cos.sv
src/rbag_alpha.sv
src/radial_blob_alpha_generator.sv
dv/radial_blob_alpha_generator_tb.sv
